/* hdl/e2q_pkg.sv */
`default_nettype none
package e2q_pkg;

  localparam int STEPS         = 18;
  localparam int CW            = 33;  // cordic x/y and sin/cos width, Q2.30
  localparam int ZW            = 32;  // cordic angle width, degrees * 2^23
  localparam int AW            = 17;  // half angle in 1/128 degree after negation
  localparam int TW            = 34;  // rounded product width
  localparam int PW            = 2 * CW;
  localparam int P2W           = TW + CW;
  localparam int SW            = TW + 2;
  localparam int FRAC          = 30;
  localparam int TURN_UNITS    = 46080;
  localparam int QUARTER_UNITS = 11520;

  localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_TBL [STEPS] = '{
    32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
    32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
    32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
    32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
    32'sd7334,      32'sd3667
  };

  localparam logic signed [PW-1:0]  RND_P  = PW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [P2W-1:0] RND_Q  = P2W'(64'sd1 <<< (FRAC - 1));

  typedef logic [1:0] quad_t;

  typedef struct packed {
    quad_t                quad;
    logic signed [ZW-1:0] z;
  } red_t;

  // half angle mod one turn, split into quadrant and residue angle
  function automatic red_t angle_reduce(input logic signed [AW-1:0] u);
    logic [AW-1:0] m;
    logic [AW-1:0] r;
    red_t          o;
    m = u[AW-1] ? AW'(u + AW'(TURN_UNITS)) : u;
    if (m >= AW'(3 * QUARTER_UNITS)) begin
      o.quad = 2'd3;
      r      = m - AW'(3 * QUARTER_UNITS);
    end else if (m >= AW'(2 * QUARTER_UNITS)) begin
      o.quad = 2'd2;
      r      = m - AW'(2 * QUARTER_UNITS);
    end else if (m >= AW'(QUARTER_UNITS)) begin
      o.quad = 2'd1;
      r      = m - AW'(QUARTER_UNITS);
    end else begin
      o.quad = 2'd0;
      r      = m;
    end
    o.z = $signed({2'b00, r[13:0], 16'b0});
    return o;
  endfunction

  function automatic logic signed [TW-1:0] rnd_p(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + RND_P) >>> FRAC;
    return t[TW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] rnd_q(input logic signed [P2W-1:0] p);
    logic signed [P2W-1:0] t;
    t = (p + RND_Q) >>> FRAC;
    return t[TW-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/euler_to_quaternion_unit.sv */
// a request passes through 25 register stages from the accepting edge to result valid
// throughput: one request per cycle when not stalled; 18 cordic stages, three lanes in parallel
// stages advance independently, so bubbles collapse under output backpressure
// reset (rst_n, synchronous, active low) clears all stage valid bits
`default_nettype none
module euler_to_quaternion_unit #(
  parameter int QUAT_WIDTH = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  signed [15:0]          in_roll_angle,
  input  wire  signed [15:0]          in_pitch_angle,
  input  wire  signed [15:0]          in_heading_angle,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [QUAT_WIDTH-1:0] out_quat_x,
  output logic signed [QUAT_WIDTH-1:0] out_quat_y,
  output logic signed [QUAT_WIDTH-1:0] out_quat_z,
  output logic signed [QUAT_WIDTH-1:0] out_quat_w
);
  import e2q_pkg::*;

  localparam int NS   = STEPS + 7;
  localparam int S_MAP = STEPS + 1;
  localparam int S_M1  = STEPS + 2;
  localparam int S_T   = STEPS + 3;
  localparam int S_M2  = STEPS + 4;
  localparam int S_SUM = STEPS + 5;
  localparam int S_OUT = STEPS + 6;
  localparam int VW   = SW + 1;
  localparam int SH   = 31 - QUAT_WIDTH;
  localparam int RSH  = (SH > 0) ? SH : 0;
  localparam int RNDS = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [VW-1:0] RND_O = (SH > 0) ? VW'(64'sd1 <<< RNDS) : '0;
  localparam logic signed [VW-1:0] Q_HI  = VW'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] Q_LO  = VW'(-(64'sd1 <<< (QUAT_WIDTH - 1)));

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  // handshake: each stage takes new data when it is empty or its successor moves
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // lanes: 0 yaw (negated heading), 1 pitch, 2 negated roll
  quad_t                q_r [0:STEPS][3];
  logic signed [ZW-1:0] z_r [0:STEPS][3];
  logic signed [CW-1:0] x_r [1:STEPS][3];
  logic signed [CW-1:0] y_r [1:STEPS][3];
  red_t                 red_nxt [3];

  always_comb begin
    red_nxt[0] = angle_reduce(AW'(0) - AW'(in_heading_angle));
    red_nxt[1] = angle_reduce(AW'(in_pitch_angle));
    red_nxt[2] = angle_reduce(AW'(0) - AW'(in_roll_angle));
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        q_r[0][l] <= red_nxt[l].quad;
        z_r[0][l] <= red_nxt[l].z;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] xin [3];
    logic signed [CW-1:0] yin [3];
    logic signed [CW-1:0] x_nxt [3];
    logic signed [CW-1:0] y_nxt [3];
    logic signed [ZW-1:0] z_nxt [3];

    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          xin[l] = CORDIC_START;
          yin[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          xin[l] = x_r[i][l];
          yin[l] = y_r[i][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (!z_r[i][l][ZW-1]) begin
          x_nxt[l] = xin[l] - (yin[l] >>> i);
          y_nxt[l] = yin[l] + (xin[l] >>> i);
          z_nxt[l] = z_r[i][l] - ATAN_TBL[i];
        end else begin
          x_nxt[l] = xin[l] + (yin[l] >>> i);
          y_nxt[l] = yin[l] - (xin[l] >>> i);
          z_nxt[l] = z_r[i][l] + ATAN_TBL[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        for (int l = 0; l < 3; l++) begin
          x_r[i+1][l] <= x_nxt[l];
          y_r[i+1][l] <= y_nxt[l];
          z_r[i+1][l] <= z_nxt[l];
          q_r[i+1][l] <= q_r[i][l];
        end
      end
    end
  end

  // quadrant fold
  logic signed [CW-1:0] s_r [3];
  logic signed [CW-1:0] c_r [3];
  logic signed [CW-1:0] s_nxt [3];
  logic signed [CW-1:0] c_nxt [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      case (q_r[STEPS][l])
        2'd0: begin
          c_nxt[l] = x_r[STEPS][l];
          s_nxt[l] = y_r[STEPS][l];
        end
        2'd1: begin
          c_nxt[l] = -y_r[STEPS][l];
          s_nxt[l] = x_r[STEPS][l];
        end
        2'd2: begin
          c_nxt[l] = -x_r[STEPS][l];
          s_nxt[l] = -y_r[STEPS][l];
        end
        default: begin
          c_nxt[l] = y_r[STEPS][l];
          s_nxt[l] = -x_r[STEPS][l];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_MAP]) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  // yaw * pitch products; the zero terms of the axis quaternions drop out
  logic signed [PW-1:0] pm_r [4];
  logic signed [CW-1:0] s3_m1_r, c3_m1_r, s3_t_r, c3_t_r;

  always_ff @(posedge clk) begin
    if (rdy[S_M1]) begin
      pm_r[0] <= c_r[0] * s_r[1];
      pm_r[1] <= s_r[0] * c_r[1];
      pm_r[2] <= s_r[0] * s_r[1];
      pm_r[3] <= c_r[0] * c_r[1];
      s3_m1_r <= s_r[2];
      c3_m1_r <= c_r[2];
    end
  end

  logic signed [TW-1:0] t_r [4];

  always_ff @(posedge clk) begin
    if (rdy[S_T]) begin
      t_r[0] <= rnd_p(pm_r[0]);
      t_r[1] <= rnd_p(pm_r[1]);
      t_r[2] <= -rnd_p(pm_r[2]);
      t_r[3] <= rnd_p(pm_r[3]);
      s3_t_r <= s3_m1_r;
      c3_t_r <= c3_m1_r;
    end
  end

  // (yaw * pitch) * roll products
  logic signed [P2W-1:0] qm_r [8];

  always_ff @(posedge clk) begin
    if (rdy[S_M2]) begin
      qm_r[0] <= t_r[0] * c3_t_r;
      qm_r[1] <= t_r[1] * s3_t_r;
      qm_r[2] <= t_r[0] * s3_t_r;
      qm_r[3] <= t_r[1] * c3_t_r;
      qm_r[4] <= t_r[3] * s3_t_r;
      qm_r[5] <= t_r[2] * c3_t_r;
      qm_r[6] <= t_r[3] * c3_t_r;
      qm_r[7] <= t_r[2] * s3_t_r;
    end
  end

  logic signed [SW-1:0] sum_r [4];

  always_ff @(posedge clk) begin
    if (rdy[S_SUM]) begin
      sum_r[0] <= SW'(rnd_q(qm_r[0])) + SW'(rnd_q(qm_r[1]));
      sum_r[1] <= SW'(rnd_q(qm_r[3])) - SW'(rnd_q(qm_r[2]));
      sum_r[2] <= SW'(rnd_q(qm_r[4])) + SW'(rnd_q(qm_r[5]));
      sum_r[3] <= SW'(rnd_q(qm_r[6])) - SW'(rnd_q(qm_r[7]));
    end
  end

  // round to output precision and saturate
  logic signed [VW-1:0]         ov [4];
  logic signed [VW-1:0]         ovr [4];
  logic signed [QUAT_WIDTH-1:0] oq_nxt [4];
  logic signed [QUAT_WIDTH-1:0] oq_r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ov[k] = VW'(sum_r[k]);
      if (SH > 0) begin
        ovr[k] = (ov[k] + RND_O) >>> RSH;
      end else if (SH < 0) begin
        ovr[k] = ov[k] <<< 1;
      end else begin
        ovr[k] = ov[k];
      end
      if (ovr[k] > Q_HI) begin
        ovr[k] = Q_HI;
      end else if (ovr[k] < Q_LO) begin
        ovr[k] = Q_LO;
      end
      oq_nxt[k] = ovr[k][QUAT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      oq_r <= oq_nxt;
    end
  end

  assign out_quat_x = oq_r[0];
  assign out_quat_y = oq_r[1];
  assign out_quat_z = oq_r[2];
  assign out_quat_w = oq_r[3];

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS-1] |-> in_ready)
    else $error("pipeline refused a request with an empty output stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request did not enter the first stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("stage valid bits not cleared by reset");
`endif
endmodule
`default_nettype wire
